### rtl/sha1sh_pkg.sv
// Shared types, constants and command/status structs for the SHA-1 stream hasher.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package sha1sh_pkg;

    // Initial chaining values.
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    // Round constants, one per group of twenty rounds.
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // Padding marker and the buffer positions that matter to padding.
    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [5:0] FILL_LEN_POS = 6'd56;
    localparam logic [5:0] FILL_LAST    = 6'd63;

    // Round counter limits.
    localparam int         ROUND_W     = 7;
    localparam logic [6:0] ROUND_G1    = 7'd20;
    localparam logic [6:0] ROUND_G2    = 7'd40;
    localparam logic [6:0] ROUND_G3    = 7'd60;
    localparam logic [6:0] ROUND_FINAL = 7'd79;

    // Source of the byte shifted into the block buffer.
    typedef enum logic [1:0] {
        SEL_INPUT  = 2'd0,
        SEL_MARK   = 2'd1,
        SEL_ZERO   = 2'd2,
        SEL_LENGTH = 2'd3
    } byte_sel_t;

    // Input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last;
    } in_t;

    // Result item.
    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_mid;
        logic [31:0] digest_low;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      shift_en;
        byte_sel_t byte_sel;
        logic      len_add;
        logic      load_work;
        logic      round_en;
        logic      fold_en;
        logic      out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_last;
        logic fill_at_len;
        logic round_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/sha1sh_ctrl.sv
// Sequencing state machine of the SHA-1 stream hasher: input handshake,
// padding steps, compression and digest hand-off. Depends on sha1sh_pkg.
`default_nettype none

module sha1sh_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire sha1sh_pkg::in_t        s_data,
    input  wire sha1sh_pkg::dp_status_t status,
    output sha1sh_pkg::dp_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_FOLD  = 4'b0100,
        ST_PAD   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   pad_active_reg, pad_active_next;
    logic   marker_reg, marker_next;
    logic   len_phase_reg, len_phase_next;

    // Items are taken only while the datapath is free.
    assign s_ready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        state_next      = state_reg;
        pad_active_next = pad_active_reg;
        marker_next     = marker_reg;
        len_phase_next  = len_phase_reg;
        cmd             = '0;
        cmd.byte_sel    = sha1sh_pkg::SEL_ZERO;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.byte_present) begin
                        cmd.shift_en = 1'b1;
                        cmd.byte_sel = sha1sh_pkg::SEL_INPUT;
                        cmd.len_add  = 1'b1;
                    end
                    if (s_data.last) begin
                        pad_active_next = 1'b1;
                    end
                    if (s_data.byte_present && status.fill_last) begin
                        cmd.load_work = 1'b1;
                        state_next    = ST_ROUND;
                    end else if (s_data.last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.shift_en = 1'b1;
                if (!marker_reg) begin
                    cmd.byte_sel = sha1sh_pkg::SEL_MARK;
                    marker_next  = 1'b1;
                end else if (len_phase_reg || status.fill_at_len) begin
                    cmd.byte_sel   = sha1sh_pkg::SEL_LENGTH;
                    len_phase_next = 1'b1;
                end else begin
                    cmd.byte_sel = sha1sh_pkg::SEL_ZERO;
                end
                if (status.fill_last) begin
                    cmd.load_work = 1'b1;
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                if (status.round_last) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (len_phase_reg) begin
                    // Final block: wait until the output register can take the digest.
                    if (status.out_free) begin
                        cmd.out_load    = 1'b1;
                        pad_active_next = 1'b0;
                        marker_next     = 1'b0;
                        len_phase_next  = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    cmd.fold_en = 1'b1;
                    state_next  = pad_active_reg ? ST_PAD : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pad_active_reg <= 1'b0;
            marker_reg     <= 1'b0;
            len_phase_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pad_active_reg <= pad_active_next;
            marker_reg     <= marker_next;
            len_phase_reg  <= len_phase_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The fold step follows only the final round.
    a_fold_after_last_round: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FOLD && $past(state_reg) == ST_ROUND) |-> $past(status.round_last))
        else $error("fold entered before the last round");

    // Length bytes are appended only after the marker byte.
    a_len_after_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        len_phase_reg |-> (marker_reg && pad_active_reg))
        else $error("length phase without marker");

    // Padding flags exist only while a message is being finished.
    a_marker_in_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        marker_reg |-> pad_active_reg)
        else $error("marker flag outside padding");
`endif

endmodule

`default_nettype wire

### rtl/sha1sh_datapath.sv
// Datapath of the SHA-1 stream hasher: byte-wide block buffer that doubles as
// the message schedule window, round unit, chaining words, bit count and
// output register. Depends on sha1sh_pkg.
`default_nettype none

module sha1sh_datapath (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire sha1sh_pkg::in_t        s_data,
    input  wire sha1sh_pkg::dp_cmd_t    cmd,
    output sha1sh_pkg::dp_status_t      status,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output sha1sh_pkg::out_t            m_data
);

    logic [511:0]                     blk_reg, blk_next;
    logic [5:0]                       fill_reg, fill_next;
    logic [63:0]                      len_reg, len_next;
    logic [4:0][31:0]                 h_reg, h_next;
    logic [4:0][31:0]                 work_reg, work_next;
    logic [sha1sh_pkg::ROUND_W-1:0]   rnd_reg, rnd_next;
    logic                             m_valid_reg, m_valid_next;
    sha1sh_pkg::out_t                 m_data_reg, m_data_next;

    logic [7:0]       shift_byte;
    logic [63:0]      len_shift;
    logic [31:0]      w0, w2, w8, w13, w_mix, w_new;
    logic [31:0]      wa, wb, wc, wd, we;
    logic [31:0]      f_val, k_val, t_val;
    logic [4:0][31:0] sum;

    // Byte that enters the buffer: input, padding marker, zero or length byte.
    assign len_shift = len_reg >> {~fill_reg[2:0], 3'b000};
    always_comb begin
        case (cmd.byte_sel)
            sha1sh_pkg::SEL_INPUT:  shift_byte = s_data.data_byte;
            sha1sh_pkg::SEL_MARK:   shift_byte = sha1sh_pkg::PAD_MARK;
            sha1sh_pkg::SEL_LENGTH: shift_byte = len_shift[7:0];
            default:                shift_byte = 8'h00;
        endcase
    end

    // Schedule taps: word 0 is the oldest word of the sixteen-word window.
    assign w0    = blk_reg[511:480];
    assign w2    = blk_reg[447:416];
    assign w8    = blk_reg[255:224];
    assign w13   = blk_reg[95:64];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    assign wa = work_reg[0];
    assign wb = work_reg[1];
    assign wc = work_reg[2];
    assign wd = work_reg[3];
    assign we = work_reg[4];

    // Round function and constant for the current group of rounds.
    always_comb begin
        if (rnd_reg < sha1sh_pkg::ROUND_G1) begin
            f_val = (wb & wc) | (~wb & wd);
            k_val = sha1sh_pkg::K0;
        end else if (rnd_reg < sha1sh_pkg::ROUND_G2) begin
            f_val = wb ^ wc ^ wd;
            k_val = sha1sh_pkg::K1;
        end else if (rnd_reg < sha1sh_pkg::ROUND_G3) begin
            f_val = (wb & wc) | (wb & wd) | (wc & wd);
            k_val = sha1sh_pkg::K2;
        end else begin
            f_val = wb ^ wc ^ wd;
            k_val = sha1sh_pkg::K3;
        end
    end

    assign t_val = {wa[26:0], wa[31:27]} + f_val + we + k_val + w0;

    // Chaining words plus working variables at the end of a block.
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            sum[i] = h_reg[i] + work_reg[i];
        end
    end

    // Next values of all registers.
    always_comb begin
        blk_next     = blk_reg;
        fill_next    = fill_reg;
        len_next     = len_reg;
        h_next       = h_reg;
        work_next    = work_reg;
        rnd_next     = rnd_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        if (cmd.shift_en) begin
            blk_next  = {blk_reg[503:0], shift_byte};
            fill_next = fill_reg + 6'd1;
        end
        if (cmd.len_add) begin
            len_next = len_reg + 64'd8;
        end
        if (cmd.load_work) begin
            work_next = h_reg;
            rnd_next  = '0;
        end
        if (cmd.round_en) begin
            blk_next     = {blk_reg[479:0], w_new};
            work_next[0] = t_val;
            work_next[1] = wa;
            work_next[2] = {wb[1:0], wb[31:2]};
            work_next[3] = wc;
            work_next[4] = wd;
            rnd_next     = rnd_reg + 7'd1;
        end
        if (cmd.fold_en) begin
            h_next = sum;
        end
        if (cmd.out_load) begin
            m_data_next.digest_high = {sum[0], sum[1]};
            m_data_next.digest_mid  = {sum[2], sum[3]};
            m_data_next.digest_low  = sum[4];
            m_valid_next            = 1'b1;
            h_next                  = {sha1sh_pkg::IV4, sha1sh_pkg::IV3, sha1sh_pkg::IV2,
                                       sha1sh_pkg::IV1, sha1sh_pkg::IV0};
            len_next                = '0;
            fill_next               = '0;
        end
    end

    // State with a defined reset value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            len_reg     <= '0;
            h_reg       <= {sha1sh_pkg::IV4, sha1sh_pkg::IV3, sha1sh_pkg::IV2,
                            sha1sh_pkg::IV1, sha1sh_pkg::IV0};
            rnd_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            len_reg     <= len_next;
            h_reg       <= h_next;
            rnd_reg     <= rnd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        blk_reg    <= blk_next;
        work_reg   <= work_next;
        m_data_reg <= m_data_next;
    end

    // Status to the controller and result port.
    assign status.fill_last   = (fill_reg == sha1sh_pkg::FILL_LAST);
    assign status.fill_at_len = (fill_reg == sha1sh_pkg::FILL_LEN_POS);
    assign status.round_last  = (rnd_reg == sha1sh_pkg::ROUND_FINAL);
    assign status.out_free    = !m_valid_reg || m_ready;
    assign m_valid            = m_valid_reg;
    assign m_data             = m_data_reg;

`ifndef NO_ASSERTIONS
    // A digest never overwrites one that has not been transferred.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("digest overwritten before transfer");

    // Finishing a message restarts the count and the buffer position.
    a_restart_after_digest: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (len_reg == 64'd0 && fill_reg == 6'd0))
        else $error("message state not restarted");

    // Rounds and buffer loading never overlap.
    a_round_shift_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.round_en && cmd.shift_en))
        else $error("round step and byte shift in the same cycle");
`endif

endmodule

`default_nettype wire

### rtl/sha1_stream_hasher.sv
// SHA-1 stream hasher, top level: joins the sequencing controller and the datapath.
// Depends on sha1sh_pkg, sha1sh_ctrl and sha1sh_datapath.
//
// Usage: the s_ channel carries one item per transfer: a message byte with
// byte_present set, and last set on the item that ends the message (a last
// item without a byte is allowed, so an empty message works). The m_ channel
// carries one 160-bit digest per message, H0 first in digest_high.
// Blocks: a byte that does not complete a 64-byte block is only shifted into the buffer.
// The byte that completes a block is taken, then the 80 rounds run one after another on
// the single round unit and the result is added into the chaining words; no further item
// is taken until this is done.
// After a last item, padding enters the buffer one byte per cycle through the same
// byte-wide port, halting while a full block is compressed; one or two blocks are
// compressed, depending on buffer fill, before the digest goes to the output register.
// s_ready is high only while no block or padding work is in progress.
// A waiting digest sits in an output register; the next message is taken
// meanwhile, and only the next digest waits for m_ready if it is still unsent.
// Reset (aresetn low at a clock edge) restores the initial chaining values,
// clears the bit count and drops any pending digest.
`default_nettype none

module sha1_stream_hasher (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire sha1sh_pkg::in_t   s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output sha1sh_pkg::out_t       m_data
);

    sha1sh_pkg::dp_cmd_t    cmd;
    sha1sh_pkg::dp_status_t status;

    // Sequencing controller.
    sha1sh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .status  (status),
        .cmd     (cmd)
    );

    // Buffer, round unit and output register.
    sha1sh_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the SHA-1 stream hasher: drives byte streams with random
// gaps and checks every digest against a SHA-1 predictor kept inside the bench.
// Depends on sha1sh_pkg for the transfer structs and on the sha1_stream_hasher top level.
`default_nettype none

module tb_top;

    // Clock half period, reset length, idle watchdog, settle time, hold-off, run and report limits.
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 4;
    localparam int IDLE_LIMIT   = 20000;
    localparam int SETTLE       = 300;
    localparam int HOLD_CYCLES  = 3000;
    localparam int HOLD_AFTER   = 10;
    localparam int MIN_ITEMS    = 450;
    localparam int MIN_MSGS     = 12;
    localparam int MAX_REPORTS  = 10;

    // SHA-1 initial chaining values and round constants.
    localparam logic [31:0] H_INIT [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                           32'h10325476, 32'hC3D2E1F0};
    localparam logic [31:0] RK [4] = '{32'h5A827999, 32'h6ED9EBA1,
                                       32'h8F1BBCDC, 32'hCA62C1D6};
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    // Message lengths around the padding and block boundaries.
    localparam int EDGE_LENS [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

    typedef struct packed {
        sha1sh_pkg::in_t item;
        bit              wait_idle;
    } stim_t;

    logic             aclk    = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    sha1sh_pkg::in_t  s_data  = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    sha1sh_pkg::out_t m_data;

    sha1_stream_hasher dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Free-running clock.
    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Pending input items and the digests that are still owed.
    stim_t            stim_q [$];
    sha1sh_pkg::out_t digest_q [$];

    // Predictor state: chaining words, block buffer and message bit count.
    logic [31:0] hash_h [5];
    logic [7:0]  blk [64];
    logic [63:0] msg_bits;

    int n_offered   = 0;
    int n_taken     = 0;
    int n_digests   = 0;
    int n_errors    = 0;
    int n_bytes     = 0;
    int n_fillers   = 0;
    int cur_len     = 0;
    int max_len     = 0;
    int n_drains    = 0;
    int idle_cycles = 0;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void sha1_restart();
        for (int i = 0; i < 5; i++)
            hash_h[i] = H_INIT[i];
        msg_bits = '0;
    endfunction

    // One 80-round compression of the block buffer into the chaining words.
    function automatic void sha1_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        for (int r = 16; r < 80; r++)
            w[r] = rol32(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3]; e = hash_h[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = RK[0];
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = RK[1];
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = RK[2];
            end else begin
                f = b ^ c ^ d;
                k = RK[3];
            end
            t = rol32(a, 5) + f + e + k + w[r];
            e = d; d = c; c = rol32(b, 30); b = a; a = t;
        end
        hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d; hash_h[4] += e;
    endfunction

    function automatic void sha1_absorb(input logic [7:0] data);
        int pos;
        pos = int'(msg_bits[8:3]);
        blk[pos] = data;
        msg_bits += 64'd8;
        if (pos == 63)
            sha1_compress();
    endfunction

    // Pad with the marker, zeros and the big-endian bit count, then compress.
    function automatic sha1sh_pkg::out_t sha1_finish();
        int pos;
        pos = int'(msg_bits[8:3]);
        blk[pos] = PAD_BYTE;
        pos++;
        if (pos > 56) begin
            while (pos < 64) begin
                blk[pos] = 8'h00;
                pos++;
            end
            sha1_compress();
            pos = 0;
        end
        while (pos < 56) begin
            blk[pos] = 8'h00;
            pos++;
        end
        for (int i = 0; i < 8; i++)
            blk[56+i] = msg_bits[63-8*i -: 8];
        sha1_compress();
        return {hash_h[0], hash_h[1], hash_h[2], hash_h[3], hash_h[4]};
    endfunction

    // Applies one accepted item; returns 1 with the digest when a message ends.
    function automatic bit sha1_accept(input sha1sh_pkg::in_t item,
                                       output sha1sh_pkg::out_t dig);
        dig = '0;
        if (item.byte_present)
            sha1_absorb(item.data_byte);
        if (!item.last)
            return 1'b0;
        dig = sha1_finish();
        sha1_restart();
        return 1'b1;
    endfunction

    task automatic add_item(input logic [7:0] data, input bit present, input bit last,
                            input bit wait_idle);
        stim_t s;
        s.item.data_byte    = data;
        s.item.byte_present = present;
        s.item.last         = last;
        s.wait_idle         = wait_idle;
        stim_q.push_back(s);
    endtask

    // Queues one message of len random bytes, optionally with filler transfers mixed in.
    task automatic add_message(input int len, input bit wait_idle, input bit noisy);
        bit end_on_byte;
        bit first;
        end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        first = wait_idle;
        for (int i = 0; i < len; i++) begin
            if (noisy && $urandom_range(0, 4) == 0) begin
                add_item(8'($urandom), 1'b0, 1'b0, first);
                first = 1'b0;
            end
            add_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1), first);
            first = 1'b0;
        end
        if (!end_on_byte)
            add_item(8'($urandom), 1'b0, 1'b1, first);
    endtask

    // Accepted input transfers feed the predictor.
    always @(posedge aclk) begin
        sha1sh_pkg::out_t dig;
        if (!aresetn) begin
            sha1_restart();
        end else if (s_valid && s_ready) begin
            n_taken++;
            if (s_data.byte_present) begin
                n_bytes++;
                cur_len++;
            end else if (!s_data.last) begin
                n_fillers++;
            end
            if (sha1_accept(s_data, dig)) begin
                digest_q.push_back(dig);
                if (cur_len > max_len)
                    max_len = cur_len;
                cur_len = 0;
            end
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("Mismatch on digest %0d, %s: expected %h, got %h",
                         n_digests, name, want, got);
        end
    endfunction

    // Result transfers are checked against the oldest owed digest.
    always @(posedge aclk) begin
        sha1sh_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("Unexpected digest transfer: %h", m_data);
            end else begin
                want = digest_q.pop_front();
                check_field("digest_high", want.digest_high, m_data.digest_high);
                check_field("digest_mid", want.digest_mid, m_data.digest_mid);
                check_field("digest_low", {32'h0, want.digest_low}, {32'h0, m_data.digest_low});
            end
            n_digests++;
        end
    end

    // Sender: bursts of items with random gaps; some items wait until every owed digest has been received.
    int    gap_left   = 0;
    int    burst_left = 0;
    stim_t next_item;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && n_offered != n_taken) begin
            // Transfer still pending; hold valid and payload.
        end else if (gap_left > 0) begin
            gap_left--;
            s_valid <= 1'b0;
        end else if (stim_q.size() == 0 || (stim_q[0].wait_idle && digest_q.size() != 0)) begin
            s_valid <= 1'b0;
        end else begin
            next_item = stim_q.pop_front();
            if (next_item.wait_idle)
                n_drains++;
            s_data  <= next_item.item;
            s_valid <= 1'b1;
            n_offered++;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 60);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
                burst_left--;
            end
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off once traffic is flowing.
    int rx_mode  = 0;
    int rx_left  = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else if (!hold_done && n_digests >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_cnt  = HOLD_CYCLES;
            m_ready  <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(64, 512);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= ($urandom_range(0, 1) == 1);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 7) == 0);
                end
            endcase
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d digests owed",
                     idle_cycles, digest_q.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int n_items;
        int n_msgs;
        int sel;
        int len;

        // Directed part: empty messages, a known string, byte extremes, filler items.
        add_item(8'h00, 1'b0, 1'b1, 1'b0);
        add_item(8'h61, 1'b1, 1'b0, 1'b0);
        add_item(8'h62, 1'b1, 1'b0, 1'b0);
        add_item(8'h63, 1'b1, 1'b1, 1'b0);
        add_item(8'hFF, 1'b0, 1'b0, 1'b0);
        add_item(8'h00, 1'b1, 1'b1, 1'b0);
        add_item(8'hFF, 1'b1, 1'b1, 1'b0);
        add_item(8'h80, 1'b1, 1'b0, 1'b0);
        add_item(8'hFF, 1'b0, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b0, 1'b0);
        add_item(8'hA5, 1'b0, 1'b1, 1'b0);
        add_item(8'h5A, 1'b1, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b0, 1'b0);
        add_item(8'h3C, 1'b1, 1'b1, 1'b0);

        // Random part: mostly short messages, some at padding and block boundaries.
        n_msgs = 0;
        while (stim_q.size() < MIN_ITEMS || n_msgs < MIN_MSGS) begin
            sel = $urandom_range(0, 19);
            if (sel < 14)
                len = $urandom_range(0, 12);
            else if (sel < 17)
                len = EDGE_LENS[$urandom_range(0, 8)];
            else if (sel < 19)
                len = $urandom_range(0, 130);
            else
                len = $urandom_range(1, 20);
            add_message(len, (n_msgs == 0) || ($urandom_range(0, 9) == 0),
                        (sel == 19) || ($urandom_range(0, 7) == 0));
            n_msgs++;
        end
        n_items = stim_q.size();

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (stim_q.size() != 0 || s_valid) @(posedge aclk);
        while (digest_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("Run covered %0d input transfers: %0d digests, %0d message bytes,",
                 n_items, n_digests, n_bytes);
        $display("%0d filler items, longest message %0d bytes, %0d drain pauses, one long hold.",
                 n_fillers, max_len, n_drains);
        if (n_errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sha1_stream_hasher.f
rtl/sha1sh_pkg.sv
rtl/sha1sh_ctrl.sv
rtl/sha1sh_datapath.sv
rtl/sha1_stream_hasher.sv
sim/tb_top.sv
